FILE: hdl/slal_pkg.sv
// ----------------------------------------------------------------------------
// slal_pkg
// Shared types and constants for the sound level alarm latch: field widths,
// window length, reciprocal for the running-average divide, item kinds and
// register indexes.
// ----------------------------------------------------------------------------
package slal_pkg;

  localparam int WIN_LEN    = 5;
  localparam int SAMPLE_W   = 12;
  localparam int THR_W      = 12;
  localparam int HOLD_W     = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int PTR_W  = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int SUM_MAX = WIN_LEN * ((1 << SAMPLE_W) - 1);
  localparam int SUM_W  = $clog2(SUM_MAX + 1);

  // floor(x / WIN_LEN) == (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int SHIFT   = SUM_W + ((WIN_LEN > 1) ? $clog2(WIN_LEN) : 0);
  localparam longint RECIP = ((64'd1 << SHIFT) + WIN_LEN - 1) / WIN_LEN;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [PTR_W-1:0]  PTR_LAST     = PTR_W'(WIN_LEN - 1);
  localparam logic [HOLD_W-1:0] ELAPSED_MAX  = {HOLD_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(2100);
  localparam logic [HOLD_W-1:0] HOLD_RESET   = HOLD_W'(180000);

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_BUTTON = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_THRESHOLD = CFG_IDX_W'(0),
    REG_HOLD_TIME_MS    = CFG_IDX_W'(1)
  } reg_idx_t;

endpackage

FILE: hdl/slal_ram.sv
// ----------------------------------------------------------------------------
// slal_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module slal_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 5
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/sound_level_alarm_latch_top.sv
// ----------------------------------------------------------------------------
// sound_level_alarm_latch_top
// Moving-average threshold detector with a timed alarm latch. Samples go into
// a ring held in RAM; a running sum gives the truncated window average.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_kind, in_sample_value
//   out_     output     out_valid / out_ready alarm_active, window_average,
//                                             sound_detected, alarm_started,
//                                             alarm_stopped
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_ready is high. The ring RAM is read at
// the in_ accept edge; the update stage then does the read-modify-write and
// alarm update into the output register, which raises out_valid.
// A ring entry that was never written reads as zero through per-entry valid
// bits, so no clearing pass is needed after reset.
// out_ready low holds a full output register and the update stage behind it;
// in_ready drops only when both are full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module sound_level_alarm_latch_top
  import slal_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [SAMPLE_W-1:0]   in_sample_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_alarm_active,
  output logic [SAMPLE_W-1:0]   out_window_average,
  output logic                  out_sound_detected,
  output logic                  out_alarm_started,
  output logic                  out_alarm_stopped,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [THR_W-1:0]  thr_r;
  logic [HOLD_W-1:0] hold_r;

  // front end
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [WIN_LEN-1:0] vld_r;
  logic               in_acc, rd_en;

  // update stage
  logic                s1_v_r;
  kind_t               s1_kind_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic [PTR_W-1:0]    s1_addr_r;
  logic                s1_byp_r;
  logic [SAMPLE_W-1:0] s1_byp_data_r;
  logic                s1_go, wr_en;
  logic [SAMPLE_W-1:0] rdata, old_val;

  // block state
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic                alarm_r, alarm_nxt;
  logic [HOLD_W-1:0]   elapsed_r, elapsed_nxt;
  logic                det, started, stopped;
  logic [PROD_W-1:0]   prod;

  // output register
  logic                out_v_r;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready  = !s1_v_r || s1_go;
  assign in_acc    = in_valid && in_ready;
  assign rd_en     = in_acc && (kind_t'(in_kind) == KIND_SAMPLE);
  assign wr_en     = s1_go && (s1_kind_r == KIND_SAMPLE);
  assign ptr_nxt   = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);

  slal_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WIN_LEN)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .re    (rd_en),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      hold_r <= HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEVEL_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
        REG_HOLD_TIME_MS:    hold_r <= cfg_data[HOLD_W-1:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      vld_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (rd_en) begin
        ptr_r <= ptr_nxt;
      end
      if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // forward the entry being written, or zero for an unwritten entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_sample_r <= in_sample_value;
      s1_addr_r   <= ptr_r;
      if (wr_en && (s1_addr_r == ptr_r)) begin
        s1_byp_r      <= 1'b1;
        s1_byp_data_r <= s1_sample_r;
      end else if (!vld_r[ptr_r]) begin
        s1_byp_r      <= 1'b1;
        s1_byp_data_r <= '0;
      end else begin
        s1_byp_r      <= 1'b0;
        s1_byp_data_r <= '0;
      end
    end
  end

  assign old_val = s1_byp_r ? s1_byp_data_r : rdata;

  always_comb begin
    sum_nxt     = sum_r;
    avg_nxt     = avg_r;
    alarm_nxt   = alarm_r;
    elapsed_nxt = elapsed_r;
    det         = 1'b0;
    started     = 1'b0;
    stopped     = 1'b0;
    prod        = '0;
    case (s1_kind_r)
      KIND_SAMPLE: begin
        sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(s1_sample_r);
        prod    = PROD_W'(sum_nxt) * PROD_W'(RECIP);
        avg_nxt = prod[SHIFT +: SAMPLE_W];
        if (avg_nxt > thr_r) begin
          det = 1'b1;
          if (!alarm_r) begin
            alarm_nxt   = 1'b1;
            elapsed_nxt = '0;
            started     = 1'b1;
          end
        end
        if (alarm_nxt && (elapsed_nxt >= hold_r)) begin
          alarm_nxt = 1'b0;
          stopped   = 1'b1;
        end
      end
      KIND_TICK: begin
        if (alarm_r) begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + HOLD_W'(1);
          end
          if (elapsed_nxt >= hold_r) begin
            alarm_nxt = 1'b0;
            stopped   = 1'b1;
          end
        end
      end
      KIND_BUTTON: begin
        if (alarm_r) begin
          alarm_nxt = 1'b0;
          stopped   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      avg_r     <= '0;
      alarm_r   <= 1'b0;
      elapsed_r <= '0;
    end else if (s1_go) begin
      sum_r     <= sum_nxt;
      avg_r     <= avg_nxt;
      alarm_r   <= alarm_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_alarm_active   <= alarm_nxt;
      out_window_average <= avg_nxt;
      out_sound_detected <= det;
      out_alarm_started  <= started;
      out_alarm_stopped  <= stopped;
    end
  end

  assign out_valid = out_v_r;

  a_started_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_started |-> out_sound_detected)
    else $error("alarm started without sound detected");

  a_started_active_or_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_started |-> (out_alarm_active != out_alarm_stopped))
    else $error("alarm start result inconsistent");

  a_stopped_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alarm_stopped |-> !out_alarm_active)
    else $error("alarm still active after stop");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_LAST)
    else $error("ring pointer out of range");

  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_W'(SUM_MAX))
    else $error("running sum out of range");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid)
    else $error("update stage advanced without output");

endmodule
